// ===== rtl/hmm_low_prob_pruner_defines.svh =====
// assertion macros for the hmm low-probability pruner
// no dependencies
`ifndef HMM_LOW_PROB_PRUNER_DEFINES_SVH
`define HMM_LOW_PROB_PRUNER_DEFINES_SVH
// implication checked on every rising edge outside reset
`define HLP_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication checked on every rising edge outside reset
`define HLP_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/hlp_pkg.sv =====
// package for the hmm low-probability pruner: word types and constants
// no dependencies
package hlp_pkg;
  localparam int unsigned MAX_STATES_DEF  = 8;
  localparam int unsigned MAX_ENTRIES_DEF = 8;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  localparam logic [1:0] REG_NUM_STATES  = 2'd0;
  localparam logic [1:0] REG_NUM_ENTRIES = 2'd1;
  localparam logic [1:0] REG_MIN_PROB    = 2'd2;
  localparam logic [1:0] REG_KEEP_CONN   = 2'd3;

  typedef struct packed {
    logic [31:0] prob_in;
    logic        matrix_end;
  } in_word_t;

  typedef struct packed {
    logic [31:0] prob_out;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic        last_out;
  } out_word_t;

  // control from sequencer to the divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [3:0]  divisor;
  } div_req_t;
endpackage

// ===== rtl/hlp_ram.sv =====
// generic single-port-write, single-read ram with registered read
// no dependencies
module hlp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/hlp_div.sv =====
// restoring divider, one quotient bit per cycle, 32-bit by 4-bit
// depends on hlp_pkg
module hlp_div (
  input  logic             clk,
  input  logic             rst,
  input  hlp_pkg::div_req_t req,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] quo;
  logic [4:0]  rem;
  logic [3:0]  dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [4:0]  trial;

  assign trial    = {rem[3:0], quo[31]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        // shift in next dividend bit, subtract if it fits
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/hmm_low_prob_pruner.sv =====
// hmm low-probability pruner: loads a q1.31 matrix, prunes weak entries, emits it
// depends on hlp_pkg, hlp_ram, hlp_div and hmm_low_prob_pruner_defines.svh
//
// Matrix words are taken one per cycle while loading. The word flagged with
// matrix_end starts the prune walk; in_ready stays low until every entry has been
// emitted. All work goes through one store read port, one compare/add unit and a
// bit-serial divider. Per row, zeros and low entries are counted, then the row is
// scanned entry by entry; per low entry, the strong rows of its column are counted,
// the share is divided, the entry is cleared and the share is spread to the strong
// entries by read-modify-write. The output walk reads each entry, waits for the
// data, then presents it until out_ready takes it. No clearing pass: unwritten
// entries are undefined.
module hmm_low_prob_pruner #(
  parameter int unsigned MAX_STATES  = hlp_pkg::MAX_STATES_DEF,
  parameter int unsigned MAX_ENTRIES = hlp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hlp_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hlp_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  localparam int unsigned DEPTH = MAX_STATES * MAX_ENTRIES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CNT   = 4'd1;  // count zeros and lows of row
  localparam logic [3:0] S_SCAN  = 4'd2;  // look for next low entry
  localparam logic [3:0] S_STR   = 4'd3;  // count strong rows in column
  localparam logic [3:0] S_DIV   = 4'd4;  // wait for share
  localparam logic [3:0] S_CLR   = 4'd5;  // clear the low entry
  localparam logic [3:0] S_SPR   = 4'd6;  // add share to strong entries
  localparam logic [3:0] S_OUT   = 4'd7;  // emit walk
  localparam logic [3:0] S_OWAIT = 4'd8;

  // configuration registers
  logic [3:0]  num_states, num_entries, keep_conn;
  logic [31:0] min_prob;

  logic [3:0] state;
  logic [CW-1:0] load_count;
  logic [3:0] ns, ne;          // clamped sizes
  logic [3:0] row, col, idx;   // walk counters
  logic [3:0] zl_cnt, str_cnt;
  logic [31:0] cur_v;
  logic        rd_pend;        // read issued last cycle

  // store port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  hlp_pkg::div_req_t div_req;
  logic        div_done;
  logic [31:0] share;

  hlp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  hlp_div u_div (.clk, .rst, .req(div_req), .done(div_done), .quotient(share));

  assign cfg_ready = (state == S_LOAD);
  assign in_ready  = (state == S_LOAD);

  // clamp sizes
  always_comb begin
    ns = (num_states == 4'd0) ? 4'd1 :
         (num_states > 4'(MAX_STATES)) ? 4'(MAX_STATES) : num_states;
    ne = (num_entries == 4'd0) ? 4'd1 :
         (num_entries > 4'(MAX_ENTRIES)) ? 4'(MAX_ENTRIES) : num_entries;
  end

  function automatic logic [AW-1:0] addr_of(logic [3:0] r, logic [3:0] c, logic [3:0] n);
    logic [7:0] a;
    a = r * n + {4'd0, c};
    return a[AW-1:0];
  endfunction

  logic [32:0] sum;
  logic        is_low, is_strong;
  assign is_strong = (rdata >= min_prob);
  assign is_low    = (rdata != 32'd0) && !is_strong;
  assign sum       = {1'b0, rdata} + {1'b0, share};

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // read address follows the walk
  always_comb begin
    case (state)
      S_STR:   raddr = addr_of(idx, col, ne);
      S_CNT, S_SCAN, S_SPR: raddr = addr_of(row, idx, ne);
      S_OUT, S_OWAIT: raddr = addr_of(row, col, ne);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (state == S_LOAD) begin
      we    = in_acc && (load_count < CW'(DEPTH));
      waddr = load_count[AW-1:0];
      wdata = (in_data.prob_in > hlp_pkg::ONE_Q31) ? hlp_pkg::ONE_Q31 : in_data.prob_in;
    end else if (state == S_CLR) begin
      we    = 1'b1;
      waddr = addr_of(row, col, ne);
    end else if (state == S_SPR && rd_pend && is_strong) begin
      we    = 1'b1;
      waddr = addr_of(row, idx - 4'd1, ne);
      wdata = sum[32] || (sum[31:0] > hlp_pkg::ONE_Q31) ? hlp_pkg::ONE_Q31 : sum[31:0];
    end
  end

  always_comb begin
    div_req.start    = (state == S_STR) && rd_pend && (idx == ns)
                       && ({4'd0, str_cnt} + {7'd0, is_strong} > {4'd0, keep_conn});
    div_req.dividend = cur_v;
    div_req.divisor  = zl_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      load_count  <= '0;
      num_states  <= 4'd8;
      num_entries <= 4'd8;
      min_prob    <= 32'd2147484;
      keep_conn   <= 4'd1;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      row <= '0; col <= '0; idx <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (cfg_valid) begin
            case (cfg_index)
              hlp_pkg::REG_NUM_STATES:  num_states  <= cfg_data[3:0];
              hlp_pkg::REG_NUM_ENTRIES: num_entries <= cfg_data[3:0];
              hlp_pkg::REG_MIN_PROB:    min_prob    <= cfg_data;
              hlp_pkg::REG_KEEP_CONN:   keep_conn   <= cfg_data[3:0];
              default: ;
            endcase
          end
          if (in_acc) begin
            if (in_data.matrix_end) begin
              load_count <= '0;
              state      <= S_CNT;
              row <= '0; idx <= '0; zl_cnt <= '0; rd_pend <= 1'b0;
            end else if (load_count < CW'(DEPTH)) begin
              load_count <= load_count + CW'(1);
            end
          end
        end
        S_CNT: begin
          // issue reads idx=0..ne-1, count each entry in the cycle after its read
          if (rd_pend && (rdata == 32'd0 || is_low)) zl_cnt <= zl_cnt + 4'd1;
          if (idx == ne) begin
            rd_pend <= 1'b0;
            if (rd_pend) begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end else begin
            idx     <= idx + 4'd1;
            rd_pend <= 1'b1;
          end
        end
        S_SCAN: begin
          // read entry idx of the row; lows are found against current contents
          if (!rd_pend) begin
            if (idx == ne) begin
              if (row == ns - 4'd1) begin
                state <= S_OUT;
                row <= '0; col <= '0;
              end else begin
                row <= row + 4'd1; idx <= '0; zl_cnt <= '0;
                state <= S_CNT;
              end
            end else begin
              rd_pend <= 1'b1;
            end
          end else begin
            rd_pend <= 1'b0;
            if (is_low) begin
              cur_v   <= rdata;
              col     <= idx;
              idx     <= '0;
              str_cnt <= '0;
              state   <= S_STR;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        S_STR: begin
          if (rd_pend) str_cnt <= str_cnt + {3'd0, is_strong};
          if (idx == ns) begin
            rd_pend <= 1'b0;
            if (rd_pend) begin
              if (div_req.start) begin
                state <= S_DIV;
              end else begin
                idx   <= col + 4'd1;
                state <= S_SCAN;
              end
            end
          end else begin
            idx     <= idx + 4'd1;
            rd_pend <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_CLR;
        end
        S_CLR: begin
          idx     <= '0;
          rd_pend <= 1'b0;
          state   <= S_SPR;
        end
        S_SPR: begin
          // alternate read and write so each entry is read before its update
          if (rd_pend) begin
            rd_pend <= 1'b0;
            if (idx == ne) begin
              idx   <= col + 4'd1;
              state <= S_SCAN;
            end
          end else begin
            idx     <= idx + 4'd1;
            rd_pend <= 1'b1;
          end
        end
        S_OUT: begin
          // read issued this cycle, data lands next
          state <= S_OWAIT;
        end
        S_OWAIT: begin
          if (!out_valid) begin
            out_valid          <= 1'b1;
            out_data.prob_out  <= rdata;
            out_data.row_index <= row[2:0];
            out_data.col_index <= col[2:0];
            out_data.last_out  <= (row == ns - 4'd1) && (col == ne - 4'd1);
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (out_data.last_out) begin
              state <= S_LOAD;
            end else begin
              if (col == ne - 4'd1) begin
                col <= '0; row <= row + 4'd1;
              end else begin
                col <= col + 4'd1;
              end
              state <= S_OUT;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`include "hmm_low_prob_pruner_defines.svh"
  `HLP_ASSERT_IMP(a_no_out_in_load, state == S_LOAD, !out_valid)
  `HLP_ASSERT_IMP(a_div_only_in_str, div_req.start, state == S_STR)
  `HLP_ASSERT_NEXT(a_last_ret_load, out_valid && out_ready && out_data.last_out,
    state == S_LOAD)
endmodule
